// ===== rtl/sccs_pkg.sv =====
// ----------------------------------------------------------------------------
// sccs_pkg: shared definitions for the strongly connected components block
// Field widths, search sequencer states and the edge scan flag group.
// ----------------------------------------------------------------------------
package sccs_pkg;

   // default node capacity of the block
   localparam int MAX_NODES_DEFAULT = 64;

   // fixed field widths of the transaction payloads
   localparam int ROW_W   = 64;
   localparam int INDEX_W = 6;
   localparam int COUNT_W = 7;

   // adjacency bits examined by the edge scan unit per cycle
   localparam int SCAN_LANES = 8;

   // node_count after reset
   localparam logic [COUNT_W-1:0] CSR_RESET = 7'd64;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ROOT,
      ST_SCAN,
      ST_EDGE,
      ST_POP_RD,
      ST_POP,
      ST_RET,
      ST_RET_LD,
      ST_RET_MIN,
      ST_OUT_RD,
      ST_OUT_LD,
      ST_OUT_WAIT
   } state_type;

   // result flags of one edge scan step
   typedef struct packed {
      logic hit;    // an edge was found in the window
      logic done;   // no edge left for this node
   } scan_flags_type;

endpackage

// ===== rtl/sccs_ram.sv =====
// ----------------------------------------------------------------------------
// sccs_ram: simple dual port ram
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sccs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/sccs_edge_scan.sv =====
// ----------------------------------------------------------------------------
// sccs_edge_scan: edge scan unit
// Shifts the adjacency row to the cursor and finds the first usable edge
// among a small window of lanes.
// ----------------------------------------------------------------------------
module sccs_edge_scan #(
   parameter int MAX_NODES = sccs_pkg::MAX_NODES_DEFAULT
) (
   input  logic [sccs_pkg::ROW_W-1:0]       row,
   input  logic [$clog2(MAX_NODES+1)-1:0]   cursor,
   input  logic [$clog2(MAX_NODES)-1:0]     node,
   input  logic [$clog2(MAX_NODES+1)-1:0]   count,
   output sccs_pkg::scan_flags_type         flags,
   output logic [$clog2(MAX_NODES)-1:0]     target,
   output logic [$clog2(MAX_NODES+1)-1:0]   next_cursor
);

   localparam int IDX_W = $clog2(MAX_NODES);
   localparam int CNT_W = $clog2(MAX_NODES + 1);
   localparam int J_W   = $clog2(MAX_NODES + sccs_pkg::SCAN_LANES + 1);

   logic [sccs_pkg::ROW_W-1:0]        window;
   logic [sccs_pkg::SCAN_LANES-1:0]   cand;
   logic [J_W-1:0]                    lane_j [sccs_pkg::SCAN_LANES];
   logic [J_W-1:0]                    first_j;
   logic                              hit;

   assign window = row >> cursor;

   always_comb begin
      for (int k = 0; k < sccs_pkg::SCAN_LANES; k++) begin
         lane_j[k] = J_W'(cursor) + J_W'(k);
         cand[k]   = window[k] && (lane_j[k] < J_W'(count)) && (lane_j[k] != J_W'(node));
      end
   end

   // lowest lane wins
   always_comb begin
      hit     = 1'b0;
      first_j = '0;
      for (int k = sccs_pkg::SCAN_LANES - 1; k >= 0; k--) begin
         if (cand[k]) begin
            hit     = 1'b1;
            first_j = lane_j[k];
         end
      end
   end

   assign flags.hit  = hit;
   assign flags.done = !hit &&
                       (J_W'(cursor) + J_W'(sccs_pkg::SCAN_LANES) >= J_W'(count));
   assign target      = first_j[IDX_W-1:0];
   assign next_cursor = hit ? CNT_W'(first_j + J_W'(1))
                            : CNT_W'(J_W'(cursor) + J_W'(sccs_pkg::SCAN_LANES));

endmodule

// ===== rtl/strongly_connected_components.sv =====
// ----------------------------------------------------------------------------
// strongly_connected_components: tarjan component search on a bit matrix
// Loads adjacency rows, runs an iterative depth first search with explicit
// stacks on the row marked last, then streams one result per node.
// ----------------------------------------------------------------------------
//
// channel  direction  ports                                 transaction
// req      in         row_index, row_bits, last_row         one adjacency row
// rsp      out        node_index, component_id, count, ...  one node result
// csr      in         data                                  node_count write
//
// sequence: a row that is not last is only stored; the last row starts the
//   search, which enters each node, scans its row one 8-bit window at a time,
//   passes ST_EDGE per edge to an open node, pops a closing component via
//   ST_POP_RD and ST_POP, and resumes a parent via ST_RET_LD and ST_RET_MIN
// results: each read from the component ram, then held in rsp until taken
// reset: synchronous; node_count returns to 64, adjacency stays undefined
// stalls: req_ready is high only while idle; rsp holds its registered result
//
module strongly_connected_components #(
   parameter int MAX_NODES = sccs_pkg::MAX_NODES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   // row input
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [sccs_pkg::INDEX_W-1:0]  req_row_index,
   input  logic [sccs_pkg::ROW_W-1:0]    req_row_bits,
   input  logic                          req_last_row,
   // result output
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [sccs_pkg::INDEX_W-1:0]  rsp_node_index,
   output logic [sccs_pkg::INDEX_W-1:0]  rsp_component_id,
   output logic [sccs_pkg::COUNT_W-1:0]  rsp_component_count,
   output logic                          rsp_strongly_connected,
   output logic                          rsp_last_result,
   // node_count register
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [sccs_pkg::COUNT_W-1:0]  csr_data
);

   localparam int IDX_W = $clog2(MAX_NODES);
   localparam int CNT_W = $clog2(MAX_NODES + 1);
   localparam int SS_W  = IDX_W + CNT_W;

   // ---------------------------------------------------------------- state
   sccs_pkg::state_type state_ff, state_in;

   logic [sccs_pkg::COUNT_W-1:0] csr_ff;
   logic [CNT_W-1:0]     n_ff, n_in;             // clamped node count
   logic [CNT_W-1:0]     root_ff, root_in;       // outer loop root
   logic [CNT_W-1:0]     time_ff, time_in;       // visit time counter
   logic [CNT_W-1:0]     comp_ff, comp_in;       // component counter
   logic [CNT_W-1:0]     ntop_ff, ntop_in;       // node stack fill
   logic [CNT_W-1:0]     sdepth_ff, sdepth_in;   // frames saved below current
   logic [IDX_W-1:0]     cur_v_ff, cur_v_in;     // node being expanded
   logic [CNT_W-1:0]     cursor_ff, cursor_in;   // its edge cursor
   logic [IDX_W-1:0]     cur_low_ff, cur_low_in; // its low link
   logic [IDX_W-1:0]     cur_vt_ff, cur_vt_in;   // its visit time
   logic [MAX_NODES-1:0] visited_ff, visited_in;
   logic [MAX_NODES-1:0] assigned_ff, assigned_in;
   logic [IDX_W-1:0]     out_k_ff, out_k_in;

   // result register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [sccs_pkg::INDEX_W-1:0] rsp_node_ff, rsp_node_in;
   logic [sccs_pkg::INDEX_W-1:0] rsp_comp_ff, rsp_comp_in;
   logic [sccs_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic                         rsp_sc_ff, rsp_sc_in;
   logic                         rsp_last_ff, rsp_last_in;

   // ------------------------------------------------------------- memories
   logic                      adj_we, adj_re;
   logic [IDX_W-1:0]          adj_wa, adj_ra;
   logic [sccs_pkg::ROW_W-1:0] adj_rd;

   logic                      vt_we, vt_re;
   logic [IDX_W-1:0]          vt_wa, vt_ra, vt_wd, vt_rd;

   logic                      low_we, low_re;
   logic [IDX_W-1:0]          low_wa, low_ra, low_wd, low_rd;

   logic                      co_we, co_re;
   logic [IDX_W-1:0]          co_wa, co_ra, co_wd, co_rd;

   logic                      ns_we, ns_re;
   logic [IDX_W-1:0]          ns_wa, ns_ra, ns_wd, ns_rd;

   logic                      ss_we, ss_re;
   logic [IDX_W-1:0]          ss_wa, ss_ra;
   logic [SS_W-1:0]           ss_wd, ss_rd;

   // adjacency rows, read for the node under expansion
   sccs_ram #(.WIDTH(sccs_pkg::ROW_W), .DEPTH(MAX_NODES)) u_adj (
      .clock(clock), .wr_en(adj_we), .wr_addr(adj_wa), .wr_data(req_row_bits),
      .rd_en(adj_re), .rd_addr(adj_ra), .rd_data(adj_rd)
   );

   sccs_ram #(.WIDTH(IDX_W), .DEPTH(MAX_NODES)) u_visit_time (
      .clock(clock), .wr_en(vt_we), .wr_addr(vt_wa), .wr_data(vt_wd),
      .rd_en(vt_re), .rd_addr(vt_ra), .rd_data(vt_rd)
   );

   // low link of nodes parked on the search stack
   sccs_ram #(.WIDTH(IDX_W), .DEPTH(MAX_NODES)) u_low_link (
      .clock(clock), .wr_en(low_we), .wr_addr(low_wa), .wr_data(low_wd),
      .rd_en(low_re), .rd_addr(low_ra), .rd_data(low_rd)
   );

   sccs_ram #(.WIDTH(IDX_W), .DEPTH(MAX_NODES)) u_component_of (
      .clock(clock), .wr_en(co_we), .wr_addr(co_wa), .wr_data(co_wd),
      .rd_en(co_re), .rd_addr(co_ra), .rd_data(co_rd)
   );

   sccs_ram #(.WIDTH(IDX_W), .DEPTH(MAX_NODES)) u_node_stack (
      .clock(clock), .wr_en(ns_we), .wr_addr(ns_wa), .wr_data(ns_wd),
      .rd_en(ns_re), .rd_addr(ns_ra), .rd_data(ns_rd)
   );

   // search frames: parent node plus its resume cursor
   sccs_ram #(.WIDTH(SS_W), .DEPTH(MAX_NODES)) u_search_stack (
      .clock(clock), .wr_en(ss_we), .wr_addr(ss_wa), .wr_data(ss_wd),
      .rd_en(ss_re), .rd_addr(ss_ra), .rd_data(ss_rd)
   );

   // ------------------------------------------------------------ edge scan
   sccs_pkg::scan_flags_type scan_flags;
   logic [IDX_W-1:0]         scan_target;
   logic [CNT_W-1:0]         scan_next;

   sccs_edge_scan #(.MAX_NODES(MAX_NODES)) u_scan (
      .row(adj_rd), .cursor(cursor_ff), .node(cur_v_ff), .count(n_ff),
      .flags(scan_flags), .target(scan_target), .next_cursor(scan_next)
   );

   // --------------------------------------------------------- handshakes
   logic req_fire;
   logic rsp_fire;

   assign req_ready = (state_ff == sccs_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid_ff && rsp_ready;
   assign csr_ready = 1'b1;

   // ------------------------------------------------------ state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sccs_pkg::ST_IDLE;
         csr_ff       <= sccs_pkg::CSR_RESET;
         rsp_valid_ff <= 1'b0;
         visited_ff   <= '0;
         assigned_ff  <= '0;
         n_ff         <= '0;
         root_ff      <= '0;
         time_ff      <= '0;
         comp_ff      <= '0;
         ntop_ff      <= '0;
         sdepth_ff    <= '0;
         out_k_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         visited_ff   <= visited_in;
         assigned_ff  <= assigned_in;
         n_ff         <= n_in;
         root_ff      <= root_in;
         time_ff      <= time_in;
         comp_ff      <= comp_in;
         ntop_ff      <= ntop_in;
         sdepth_ff    <= sdepth_in;
         out_k_ff     <= out_k_in;
         if (csr_valid && csr_ready) begin
            csr_ff <= csr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cur_v_ff     <= cur_v_in;
      cursor_ff    <= cursor_in;
      cur_low_ff   <= cur_low_in;
      cur_vt_ff    <= cur_vt_in;
      rsp_node_ff  <= rsp_node_in;
      rsp_comp_ff  <= rsp_comp_in;
      rsp_count_ff <= rsp_count_in;
      rsp_sc_ff    <= rsp_sc_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // ------------------------------------------------------------ sequencer
   logic [IDX_W-1:0] enter_node;
   logic             do_enter;

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      root_in      = root_ff;
      time_in      = time_ff;
      comp_in      = comp_ff;
      ntop_in      = ntop_ff;
      sdepth_in    = sdepth_ff;
      cur_v_in     = cur_v_ff;
      cursor_in    = cursor_ff;
      cur_low_in   = cur_low_ff;
      cur_vt_in    = cur_vt_ff;
      visited_in   = visited_ff;
      assigned_in  = assigned_ff;
      out_k_in     = out_k_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_node_in  = rsp_node_ff;
      rsp_comp_in  = rsp_comp_ff;
      rsp_count_in = rsp_count_ff;
      rsp_sc_in    = rsp_sc_ff;
      rsp_last_in  = rsp_last_ff;

      adj_we = 1'b0;  adj_wa = req_row_index[IDX_W-1:0];
      adj_re = 1'b0;  adj_ra = cur_v_ff;
      vt_we  = 1'b0;  vt_wa  = cur_v_ff;  vt_wd  = time_ff[IDX_W-1:0];
      vt_re  = 1'b0;  vt_ra  = scan_target;
      low_we = 1'b0;  low_wa = cur_v_ff;  low_wd = cur_low_ff;
      low_re = 1'b0;  low_ra = cur_v_ff;
      co_we  = 1'b0;  co_wa  = ns_rd;     co_wd  = comp_ff[IDX_W-1:0];
      co_re  = 1'b0;  co_ra  = out_k_ff;
      ns_we  = 1'b0;  ns_wa  = ntop_ff[IDX_W-1:0];  ns_wd = cur_v_ff;
      ns_re  = 1'b0;  ns_ra  = IDX_W'(ntop_ff - CNT_W'(1));
      ss_we  = 1'b0;  ss_wa  = sdepth_ff[IDX_W-1:0];
      ss_wd  = {cur_v_ff, scan_next};
      ss_re  = 1'b0;  ss_ra  = IDX_W'(sdepth_ff - CNT_W'(1));

      do_enter   = 1'b0;
      enter_node = root_ff[IDX_W-1:0];

      unique case (state_ff)
         sccs_pkg::ST_IDLE: begin
            if (req_fire) begin
               // rows beyond the node capacity are dropped
               adj_we = (32'(req_row_index) < MAX_NODES);
               if (req_last_row) begin
                  if (csr_ff == '0) begin
                     n_in = CNT_W'(1);
                  end else if (32'(csr_ff) > MAX_NODES) begin
                     n_in = CNT_W'(MAX_NODES);
                  end else begin
                     n_in = CNT_W'(csr_ff);
                  end
                  visited_in  = '0;
                  assigned_in = '0;
                  root_in     = '0;
                  time_in     = '0;
                  comp_in     = '0;
                  ntop_in     = '0;
                  sdepth_in   = '0;
                  state_in    = sccs_pkg::ST_ROOT;
               end
            end
         end

         sccs_pkg::ST_ROOT: begin
            if (root_ff == n_ff) begin
               out_k_in = '0;
               state_in = sccs_pkg::ST_OUT_RD;
            end else if (visited_ff[root_ff[IDX_W-1:0]]) begin
               root_in = root_ff + CNT_W'(1);
            end else begin
               do_enter   = 1'b1;
               enter_node = root_ff[IDX_W-1:0];
               sdepth_in  = '0;
            end
         end

         sccs_pkg::ST_SCAN: begin
            if (scan_flags.hit) begin
               cursor_in = scan_next;
               if (!visited_ff[scan_target]) begin
                  // descend: park the current frame and its low link
                  ss_we      = 1'b1;
                  low_we     = 1'b1;
                  sdepth_in  = sdepth_ff + CNT_W'(1);
                  do_enter   = 1'b1;
                  enter_node = scan_target;
               end else if (!assigned_ff[scan_target]) begin
                  // edge to a node still on the stack
                  vt_re    = 1'b1;
                  state_in = sccs_pkg::ST_EDGE;
               end
            end else if (!scan_flags.done) begin
               cursor_in = scan_next;
            end else if (cur_low_ff == cur_vt_ff) begin
               state_in = sccs_pkg::ST_POP_RD;
            end else begin
               state_in = sccs_pkg::ST_RET;
            end
         end

         sccs_pkg::ST_EDGE: begin
            if (vt_rd < cur_low_ff) begin
               cur_low_in = vt_rd;
            end
            state_in = sccs_pkg::ST_SCAN;
         end

         sccs_pkg::ST_POP_RD: begin
            ns_re    = 1'b1;
            ntop_in  = ntop_ff - CNT_W'(1);
            state_in = sccs_pkg::ST_POP;
         end

         sccs_pkg::ST_POP: begin
            co_we = 1'b1;
            assigned_in[ns_rd] = 1'b1;
            if (ns_rd == cur_v_ff) begin
               comp_in  = comp_ff + CNT_W'(1);
               state_in = sccs_pkg::ST_RET;
            end else begin
               ns_re   = 1'b1;
               ntop_in = ntop_ff - CNT_W'(1);
            end
         end

         sccs_pkg::ST_RET: begin
            if (sdepth_ff == '0) begin
               state_in = sccs_pkg::ST_ROOT;
            end else begin
               ss_re     = 1'b1;
               sdepth_in = sdepth_ff - CNT_W'(1);
               state_in  = sccs_pkg::ST_RET_LD;
            end
         end

         sccs_pkg::ST_RET_LD: begin
            // resume the parent; cur_low still holds the child's low link
            cur_v_in  = ss_rd[SS_W-1:CNT_W];
            cursor_in = ss_rd[CNT_W-1:0];
            low_re    = 1'b1;
            low_ra    = ss_rd[SS_W-1:CNT_W];
            vt_re     = 1'b1;
            vt_ra     = ss_rd[SS_W-1:CNT_W];
            adj_re    = 1'b1;
            adj_ra    = ss_rd[SS_W-1:CNT_W];
            state_in  = sccs_pkg::ST_RET_MIN;
         end

         sccs_pkg::ST_RET_MIN: begin
            if (low_rd < cur_low_ff) begin
               cur_low_in = low_rd;
            end
            cur_vt_in = vt_rd;
            state_in  = sccs_pkg::ST_SCAN;
         end

         sccs_pkg::ST_OUT_RD: begin
            co_re    = 1'b1;
            state_in = sccs_pkg::ST_OUT_LD;
         end

         sccs_pkg::ST_OUT_LD: begin
            rsp_valid_in = 1'b1;
            rsp_node_in  = sccs_pkg::INDEX_W'(out_k_ff);
            rsp_comp_in  = sccs_pkg::INDEX_W'(co_rd);
            rsp_count_in = sccs_pkg::COUNT_W'(comp_ff);
            rsp_sc_in    = (comp_ff == CNT_W'(1));
            rsp_last_in  = (CNT_W'(out_k_ff) + CNT_W'(1) == n_ff);
            state_in     = sccs_pkg::ST_OUT_WAIT;
         end

         sccs_pkg::ST_OUT_WAIT: begin
            if (rsp_fire) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = sccs_pkg::ST_IDLE;
               end else begin
                  out_k_in = out_k_ff + IDX_W'(1);
                  co_re    = 1'b1;
                  co_ra    = out_k_ff + IDX_W'(1);
                  state_in = sccs_pkg::ST_OUT_LD;
               end
            end
         end

         default: begin
            state_in = sccs_pkg::ST_IDLE;
         end
      endcase

      // open a new node: stamp, push, and fetch its row
      if (do_enter) begin
         visited_in[enter_node] = 1'b1;
         vt_we      = 1'b1;
         vt_wa      = enter_node;
         ns_we      = 1'b1;
         ns_wd      = enter_node;
         ntop_in    = ntop_ff + CNT_W'(1);
         time_in    = time_ff + CNT_W'(1);
         cur_v_in   = enter_node;
         cursor_in  = '0;
         cur_low_in = time_ff[IDX_W-1:0];
         cur_vt_in  = time_ff[IDX_W-1:0];
         adj_re     = 1'b1;
         adj_ra     = enter_node;
         state_in   = sccs_pkg::ST_SCAN;
      end
   end

   // ------------------------------------------------------------- outputs
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_node_index         = rsp_node_ff;
   assign rsp_component_id       = rsp_comp_ff;
   assign rsp_component_count    = rsp_count_ff;
   assign rsp_strongly_connected = rsp_sc_ff;
   assign rsp_last_result        = rsp_last_ff;

endmodule

// ===== tb/tb_strongly_connected_components.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_strongly_connected_components: self-checking bench for the scc block
// Loads adjacency rows over the req channel, mirrors every accepted row in a
// local copy of the matrix and, on each row marked last, predicts the
// per-node component numbering with its own iterative tarjan search. Results
// on the rsp channel are compared field by field in order. Both channels see
// random idle and stall gaps, one long output stall and several node counts.
// ----------------------------------------------------------------------------
module tb_strongly_connected_components;

   localparam int NODES         = 64;
   localparam int IDX_W         = sccs_pkg::INDEX_W;
   localparam int CNT_W         = sccs_pkg::COUNT_W;
   localparam int ITEM_TARGET   = 370;    // rows to send before stopping
   localparam int SETTLE_CYCLES = 20;     // quiet time after the last result
   localparam int HOLD_CYCLES   = 300;    // long output stall
   localparam int STALL_LIMIT   = 60000;  // cycles with no transaction at all

   // one expected node result
   typedef struct packed {
      logic [sccs_pkg::INDEX_W-1:0] node;
      logic [sccs_pkg::INDEX_W-1:0] comp;
      logic [sccs_pkg::COUNT_W-1:0] total;
      logic                         whole;
      logic                         tail;
   } node_result_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [sccs_pkg::INDEX_W-1:0]  req_row_index = '0;
   logic [sccs_pkg::ROW_W-1:0]    req_row_bits = '0;
   logic                          req_last_row = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [sccs_pkg::INDEX_W-1:0]  rsp_node_index;
   logic [sccs_pkg::INDEX_W-1:0]  rsp_component_id;
   logic [sccs_pkg::COUNT_W-1:0]  rsp_component_count;
   logic                          rsp_strongly_connected;
   logic                          rsp_last_result;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [sccs_pkg::COUNT_W-1:0]  csr_data = '0;

   // mirror of the block's state
   logic [sccs_pkg::ROW_W-1:0]    adj_mirror [NODES];
   logic [NODES-1:0]              rows_written = '0;
   logic [sccs_pkg::COUNT_W-1:0]  node_count_mirror = sccs_pkg::CSR_RESET;

   // scratch of the component search
   int  stamp [NODES];
   int  low_mark [NODES];
   bit  seen [NODES];
   bit  closed [NODES];
   int  comp_of [NODES];
   int  node_pile [NODES];
   int  walk_node [NODES];
   int  walk_next [NODES];
   int  pile_top;
   int  walk_top;
   int  stamp_count;
   int  comp_total;

   node_result_type pending_results [$];
   int              error_count = 0;
   int              rows_sent = 0;
   bit              no_idle = 1'b0;      // stretch without gaps on either side
   bit              rsp_hold_req = 1'b0; // asks the receiver for a long stall

   strongly_connected_components dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_row_index          (req_row_index),
      .req_row_bits           (req_row_bits),
      .req_last_row           (req_last_row),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_node_index         (rsp_node_index),
      .rsp_component_id       (rsp_component_id),
      .rsp_component_count    (rsp_component_count),
      .rsp_strongly_connected (rsp_strongly_connected),
      .rsp_last_result        (rsp_last_result),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_data               (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------------

   // node_count as the search uses it: 0 acts as 1, above 64 acts as 64
   function automatic int active_nodes();
      if (node_count_mirror == 0) return 1;
      if (node_count_mirror > NODES) return NODES;
      return int'(node_count_mirror);
   endfunction

   function automatic logic [sccs_pkg::ROW_W-1:0] low_mask(input int n);
      if (n >= NODES) return '1;
      return (64'd1 << n) - 64'd1;
   endfunction

   // a search may only start once every row in use has been loaded
   function automatic bit rows_ready(input logic [sccs_pkg::INDEX_W-1:0] idx);
      logic [sccs_pkg::ROW_W-1:0] mask;
      mask = low_mask(active_nodes());
      return ((rows_written | (64'd1 << idx)) & mask) == mask;
   endfunction

   // give v its visit stamp and push it on both stacks
   function automatic void enter_node(input int v);
      stamp[v] = stamp_count;
      low_mark[v] = stamp_count;
      seen[v] = 1'b1;
      stamp_count++;
      node_pile[pile_top] = v;
      pile_top++;
      walk_node[walk_top] = v;
      walk_next[walk_top] = 0;
      walk_top++;
   endfunction

   // iterative tarjan over nodes 0..n-1, edges in increasing target order
   function automatic void find_components(input int n);
      int  root;
      int  v;
      int  j;
      int  w;
      int  p;
      int  t;
      bit  descended;
      for (int k = 0; k < NODES; k++) begin
         seen[k] = 1'b0;
         closed[k] = 1'b0;
         comp_of[k] = 0;
      end
      pile_top = 0;
      walk_top = 0;
      stamp_count = 0;
      comp_total = 0;
      for (root = 0; root < n; root++) begin
         if (seen[root]) continue;
         enter_node(root);
         while (walk_top > 0) begin
            t = walk_top - 1;
            v = walk_node[t];
            descended = 1'b0;
            for (j = walk_next[t]; j < n; j++) begin
               if (j == v || !adj_mirror[v][j]) continue;
               walk_next[t] = j + 1;
               if (!seen[j]) begin
                  enter_node(j);
                  descended = 1'b1;
                  break;
               end else if (!closed[j] && stamp[j] < low_mark[v]) begin
                  low_mark[v] = stamp[j];
               end
            end
            if (descended) continue;
            walk_next[t] = n;
            // v is a root: pop its whole component
            if (low_mark[v] == stamp[v]) begin
               do begin
                  pile_top--;
                  w = node_pile[pile_top];
                  comp_of[w] = comp_total;
                  closed[w] = 1'b1;
               end while (w != v);
               comp_total++;
            end
            walk_top--;
            if (walk_top > 0) begin
               p = walk_node[walk_top - 1];
               if (low_mark[v] < low_mark[p]) low_mark[p] = low_mark[v];
            end
         end
      end
   endfunction

   // accepted row: store it and, on the last one, queue the node results
   function automatic void record_row(input logic [sccs_pkg::INDEX_W-1:0] idx,
                                      input logic [sccs_pkg::ROW_W-1:0] bits,
                                      input logic last);
      node_result_type res;
      int              n;
      adj_mirror[idx] = bits;
      rows_written[idx] = 1'b1;
      if (!last) return;
      n = active_nodes();
      find_components(n);
      for (int k = 0; k < n; k++) begin
         res.node = k[sccs_pkg::INDEX_W-1:0];
         res.comp = comp_of[k][sccs_pkg::INDEX_W-1:0];
         res.total = comp_total[sccs_pkg::COUNT_W-1:0];
         res.whole = (comp_total == 1);
         res.tail = (k == n - 1);
         pending_results.insert(pending_results.size(), res);
      end
   endfunction

   // ---------------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------------

   task automatic report_error(input string msg);
      $display("%0t ns: %s", $realtime, msg);
      error_count++;
   endtask

   // compare every rsp transaction against the oldest expected node result
   always @(posedge clock) begin
      node_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report_error($sformatf("unexpected result for node %0d", rsp_node_index));
         end else begin
            want = pending_results.pop_front();
            if (rsp_node_index !== want.node)
               report_error($sformatf("node_index got %0d expected %0d",
                                      rsp_node_index, want.node));
            if (rsp_component_id !== want.comp)
               report_error($sformatf("node %0d component_id got %0d expected %0d",
                                      want.node, rsp_component_id, want.comp));
            if (rsp_component_count !== want.total)
               report_error($sformatf("node %0d component_count got %0d expected %0d",
                                      want.node, rsp_component_count, want.total));
            if (rsp_strongly_connected !== want.whole)
               report_error($sformatf("node %0d strongly_connected got %b expected %b",
                                      want.node, rsp_strongly_connected, want.whole));
            if (rsp_last_result !== want.tail)
               report_error($sformatf("node %0d last_result got %b expected %b",
                                      want.node, rsp_last_result, want.tail));
         end
      end
   end

   // watchdog: too long without any transaction on any channel
   always @(posedge clock) begin
      int quiet_cycles;
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // result receiver: random stalls, a long hold on request
   // ---------------------------------------------------------------------
   initial begin
      int pick;
      int run;
      forever begin
         if (rsp_hold_req) begin
            // long stall so the block stays busy and holds its input off
            rsp_hold_req = 1'b0;
            rsp_ready <= 1'b0;
            run = HOLD_CYCLES;
         end else if (no_idle) begin
            rsp_ready <= 1'b1;
            run = 1;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
               rsp_ready <= 1'b1;
               run = $urandom_range(1, 8);
            end else if (pick < 92) begin
               rsp_ready <= 1'b0;
               run = $urandom_range(1, 3);
            end else begin
               rsp_ready <= 1'b0;
               run = $urandom_range(10, 40);
            end
         end
         repeat (run) @(posedge clock);
      end
   end

   // ---------------------------------------------------------------------
   // row sender and register writes
   // ---------------------------------------------------------------------

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int pick;
      if (no_idle) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [sccs_pkg::ROW_W-1:0] rand_row();
      return {$urandom, $urandom};
   endfunction

   // one row transaction; valid stays high into the next call when no gap
   task automatic send_row(input logic [sccs_pkg::INDEX_W-1:0] idx,
                           input logic [sccs_pkg::ROW_W-1:0] bits,
                           input logic last);
      int gap;
      req_valid <= 1'b1;
      req_row_index <= idx;
      req_row_bits <= bits;
      req_last_row <= last;
      do @(posedge clock); while (!req_ready);
      record_row(idx, bits, last);
      rows_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop offering rows until every expected result is back, then settle
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // node_count is only written while the block is idle
   task automatic set_node_count(input logic [sccs_pkg::COUNT_W-1:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      node_count_mirror = value;
      csr_valid <= 1'b0;
   endtask

   // row i of a random graph on n nodes, junk above n now and then
   function automatic logic [sccs_pkg::ROW_W-1:0] graph_row(input int i, input int n,
                                                            input int shape);
      logic [sccs_pkg::ROW_W-1:0] bits;
      case (shape)
         0: bits = rand_row();
         1: bits = (64'd1 << $urandom_range(0, n - 1)) |
                   (64'd1 << $urandom_range(0, n - 1));
         2: bits = (64'd1 << ((i + 1) % n)) | ($urandom_range(0, 1) ? 64'd1 << i : 64'd0);
         default: bits = '0;
      endcase
      if ($urandom_range(0, 1)) bits |= rand_row() & ~low_mask(n);
      return bits;
   endfunction

   // well formed graph: load the rows in use, then a last row that starts it
   task automatic send_graph();
      int n;
      int shape;
      int reload;
      n = active_nodes();
      shape = $urandom_range(0, 3);
      // big graphs mostly reuse what is already loaded
      reload = (n > 16) ? 10 : 80;
      for (int i = 0; i < n; i++) begin
         if (!rows_written[i] || $urandom_range(0, 99) < reload)
            send_row(IDX_W'(i), graph_row(i, n, ($urandom_range(0, 3) == 0) ?
                                          int'($urandom_range(0, 3)) : shape), 1'b0);
      end
      if ($urandom_range(0, 3) == 0)
         send_row(IDX_W'($urandom_range(0, NODES - 1)), rand_row(), 1'b1);
      else
         send_row(IDX_W'($urandom_range(0, n - 1)), graph_row(0, n, shape), 1'b1);
   endtask

   // stray rows, some of them last when the rows in use are all loaded
   task automatic send_noise(input int count);
      logic [sccs_pkg::INDEX_W-1:0] idx;
      logic                         last;
      repeat (count) begin
         idx = IDX_W'($urandom_range(0, NODES - 1));
         last = ($urandom_range(0, 2) == 0) && rows_ready(idx);
         send_row(idx, rand_row(), last);
      end
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // reset node_count of 64: fill every row, fully connected, then reuse
   task automatic test_largest_graph();
      for (int i = 0; i < NODES; i++)
         send_row(IDX_W'(i), '1, (i == NODES - 1));
      // only row 5 loses its edges, the rest stays loaded
      send_row(6'd5, '0, 1'b1);
      drain_results();
      // count above the node capacity acts as 64
      set_node_count(7'd127);
      send_row(6'd0, '0, 1'b1);
      drain_results();
   endtask

   // small graphs with known answers
   task automatic test_special_cases();
      // single node, self edge and unused bits ignored
      set_node_count(7'd1);
      send_row(6'd0, '1, 1'b1);
      // count 0 acts as one node
      set_node_count(7'd0);
      send_row(6'd0, '0, 1'b1);
      // cycle 0-1-2 plus node 3 pointing at everything
      set_node_count(7'd4);
      send_row(6'd63, '1, 1'b0);
      send_row(6'd0, 64'hF000_0000_0000_0002, 1'b0);
      send_row(6'd1, 64'h0000_0000_0000_0004, 1'b0);
      send_row(6'd2, 64'h0000_0000_0000_0005, 1'b0);
      send_row(6'd3, '1, 1'b1);
      // rows 0 to 2 kept, node 3 isolated
      send_row(6'd3, '0, 1'b1);
      // close the loop through node 3: one component
      send_row(6'd2, 64'h0000_0000_0000_0009, 1'b0);
      send_row(6'd3, 64'h0000_0000_0000_0001, 1'b1);
      set_node_count(7'd2);
      send_row(6'd0, '0, 1'b0);
      send_row(6'd1, '1, 1'b1);
      drain_results();
   endtask

   // results held back while rows keep coming
   task automatic test_output_stall();
      set_node_count(7'd8);
      rsp_hold_req = 1'b1;
      send_graph();
      send_noise(4);
      send_graph();
      drain_results();
   endtask

   // phases of random node counts, mostly small graphs
   task automatic test_random_graphs();
      int pick;
      logic [sccs_pkg::COUNT_W-1:0] count;
      while (rows_sent < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 5) count = 7'd0;
         else if (pick < 10) count = CNT_W'($urandom_range(65, 127));
         else if (pick < 14) count = 7'd64;
         else if (pick < 24) count = CNT_W'($urandom_range(13, 40));
         else count = CNT_W'($urandom_range(1, 12));
         set_node_count(count);
         no_idle = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(2, 4)) begin
            if ($urandom_range(0, 99) < 80) send_graph();
            else send_noise($urandom_range(1, 4));
         end
         drain_results();
         no_idle = 1'b0;
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_largest_graph();
      test_special_cases();
      test_output_stall();
      test_random_graphs();
      drain_results();
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
